@@ rtl/lpsf_pkg.sv @@
// Shared types, constants and codes of the LCD pixel stream formatter.
`timescale 1ns / 1ps

package lpsf_pkg;

   // Palette storage
   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

   // Longest solid run in pixels
   localparam int MAX_RUN_PIXELS = 16;

   // Descriptor queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Register indexes and reset values
   localparam logic       CSR_COLUMN_OFFSET = 1'b0;
   localparam logic       CSR_ROW_OFFSET    = 1'b1;
   localparam logic [7:0] COLUMN_OFFSET_RST = 8'd1;
   localparam logic [7:0] ROW_OFFSET_RST    = 8'd2;

   // Input opcodes
   localparam logic [1:0] OP_WINDOW  = 2'd0;
   localparam logic [1:0] OP_PALETTE = 2'd1;
   localparam logic [1:0] OP_PIXELS  = 2'd2;
   localparam logic [1:0] OP_RUN     = 2'd3;

   // Pixel packing modes
   localparam logic [1:0] MODE_1BPP = 2'd0;
   localparam logic [1:0] MODE_4BPP = 2'd1;
   localparam logic [1:0] MODE_8BPP = 2'd2;

   // Controller command bytes
   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   // Byte positions within a window sequence and within a pixel
   localparam logic [3:0] WIN_COL_CMD = 4'd0;
   localparam logic [3:0] WIN_ROW_CMD = 4'd5;
   localparam logic [3:0] WIN_LAST    = 4'd10;
   localparam logic [3:0] PIX_LAST    = 4'd2;

   typedef enum logic [1:0] {
      KIND_WINDOW,
      KIND_PALETTE,
      KIND_PIXELS,
      KIND_RUN
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WINDOW,
      BK_PIXEL
   } bk_state_type;

   // One classified transaction as handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [8:0]  col_first;
      logic [8:0]  col_final;
      logic [8:0]  row_first;
      logic [8:0]  row_final;
      logic [7:0]  table_index;
      logic [23:0] color_value;
      logic [7:0]  pixel_byte;
      logic [1:0]  pixel_mode;
      logic [2:0]  first_pos;
      logic [4:0]  count;
   } cmd_type;

endpackage

@@ rtl/lpsf_front.sv @@
// Front end: takes input transactions, applies offsets, clips counts, fills the queue.
`timescale 1ns / 1ps

module lpsf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [7:0]            req_x_first,
   input  logic [7:0]            req_y_first,
   input  logic [7:0]            req_x_final,
   input  logic [7:0]            req_y_final,
   input  logic [7:0]            req_table_index,
   input  logic [23:0]           req_color_value,
   input  logic [7:0]            req_pixel_byte,
   input  logic [1:0]            req_pixel_mode,
   input  logic [2:0]            req_first_pixel,
   input  logic [4:0]            req_pixel_count,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  q_full,
   output logic                  q_push,
   output lpsf_pkg::cmd_type     q_data
);

   logic [7:0] col_off_ff, col_off_in;
   logic [7:0] row_off_ff, row_off_in;
   logic [3:0] avail;
   logic [4:0] clipped;
   logic [4:0] run_len;
   logic       keep;

   always_comb begin
      col_off_in = col_off_ff;
      row_off_in = row_off_ff;
      if (csr_write) begin
         case (csr_index)
            lpsf_pkg::CSR_COLUMN_OFFSET: col_off_in = csr_wdata;
            lpsf_pkg::CSR_ROW_OFFSET:    row_off_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_off_ff <= lpsf_pkg::COLUMN_OFFSET_RST;
         row_off_ff <= lpsf_pkg::ROW_OFFSET_RST;
      end else begin
         col_off_ff <= col_off_in;
         row_off_ff <= row_off_in;
      end
   end

   // Pixels left in the byte from the start position
   always_comb begin
      case (req_pixel_mode)
         lpsf_pkg::MODE_1BPP: avail = 4'd8 - {1'b0, req_first_pixel};
         lpsf_pkg::MODE_4BPP: avail = 4'd2 - {3'b000, req_first_pixel[0]};
         lpsf_pkg::MODE_8BPP: avail = 4'd1;
         default:             avail = 4'd0;
      endcase
   end

   assign clipped = (req_pixel_count > {1'b0, avail}) ? {1'b0, avail} : req_pixel_count;
   assign run_len = (req_pixel_count > 5'(lpsf_pkg::MAX_RUN_PIXELS)) ?
                    5'(lpsf_pkg::MAX_RUN_PIXELS) : req_pixel_count;

   always_comb begin
      q_data             = '0;
      q_data.col_first   = 9'(req_x_first) + 9'(col_off_ff);
      q_data.col_final   = 9'(req_x_final) + 9'(col_off_ff);
      q_data.row_first   = 9'(req_y_first) + 9'(row_off_ff);
      q_data.row_final   = 9'(req_y_final) + 9'(row_off_ff);
      q_data.table_index = req_table_index;
      q_data.color_value = req_color_value;
      q_data.pixel_byte  = req_pixel_byte;
      q_data.pixel_mode  = req_pixel_mode;
      q_data.first_pos   = (req_pixel_mode == lpsf_pkg::MODE_1BPP) ? req_first_pixel :
                           (req_pixel_mode == lpsf_pkg::MODE_4BPP) ?
                           {2'b00, req_first_pixel[0]} : 3'd0;
      keep               = 1'b0;
      case (req_opcode)
         lpsf_pkg::OP_WINDOW: begin
            q_data.kind = lpsf_pkg::KIND_WINDOW;
            keep        = 1'b1;
         end
         lpsf_pkg::OP_PALETTE: begin
            q_data.kind = lpsf_pkg::KIND_PALETTE;
            keep        = ({1'b0, req_table_index} < 9'(lpsf_pkg::PAL_DEPTH));
         end
         lpsf_pkg::OP_PIXELS: begin
            q_data.kind  = lpsf_pkg::KIND_PIXELS;
            q_data.count = clipped;
            keep         = (clipped != 5'd0);
         end
         lpsf_pkg::OP_RUN: begin
            q_data.kind  = lpsf_pkg::KIND_RUN;
            q_data.count = run_len;
            keep         = (run_len != 5'd0);
         end
         default: ;
      endcase
   end

   // Drop transactions that produce nothing and touch no state
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && keep;

endmodule

@@ rtl/lpsf_queue.sv @@
// Short descriptor queue decoupling the front end from the byte sequencer.
`timescale 1ns / 1ps

module lpsf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lpsf_pkg::cmd_type   push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output lpsf_pkg::cmd_type   head
);

   lpsf_pkg::cmd_type             entry_ff [lpsf_pkg::QUEUE_DEPTH];
   logic [lpsf_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lpsf_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lpsf_pkg::QUEUE_CW-1:0] count_ff, count_in;

   function automatic logic [lpsf_pkg::QUEUE_AW-1:0] bump(
      input logic [lpsf_pkg::QUEUE_AW-1:0] ptr);
      return (ptr == lpsf_pkg::QUEUE_AW'(lpsf_pkg::QUEUE_DEPTH - 1)) ?
             '0 : ptr + lpsf_pkg::QUEUE_AW'(1);
   endfunction

   assign full  = (count_ff == lpsf_pkg::QUEUE_CW'(lpsf_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + lpsf_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - lpsf_pkg::QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/lpsf_back.sv @@
// Back end: palette memory and the sequencer that emits tagged bytes.
`timescale 1ns / 1ps

module lpsf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  lpsf_pkg::cmd_type   q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_is_data,
   output logic                rsp_last_byte
);

   lpsf_pkg::bk_state_type state_ff, state_in;
   lpsf_pkg::cmd_type      cmd_ff, cmd_in;
   logic [3:0]             bcnt_ff, bcnt_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic [2:0]             pos_ff, pos_in;

   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_data_ff, out_data_in;
   logic                   out_last_ff, out_last_in;

   logic [23:0]            palette_ff [lpsf_pkg::PAL_DEPTH];
   logic [23:0]            rd_data_ff;
   logic                   rd_zero_ff, rd_zero_in;
   logic                   rd_en;
   logic [7:0]             rd_idx;
   logic                   pal_we;

   logic                   load_ok;
   logic                   pix_done;
   logic [23:0]            pix_colour;
   logic                   mode18;
   logic [7:0]             win_byte;
   logic                   win_data;
   logic [7:0]             pix_byte;

   // Palette index of the pixel at a given position in the packed byte
   function automatic logic [7:0] pixel_index(input logic [7:0] pbyte,
                                              input logic [1:0] mode,
                                              input logic [2:0] pos);
      logic [7:0] idx;
      case (mode)
         lpsf_pkg::MODE_1BPP: idx = {7'd0, pbyte[~pos]};
         lpsf_pkg::MODE_4BPP: idx = pos[0] ? {4'd0, pbyte[3:0]} : {4'd0, pbyte[7:4]};
         default:             idx = pbyte;
      endcase
      return idx;
   endfunction

   assign load_ok  = !out_valid_ff || !rsp_stall;
   assign pix_done = load_ok && (bcnt_ff == lpsf_pkg::PIX_LAST);

   // Window byte at the current position
   always_comb begin
      win_data = 1'b1;
      case (bcnt_ff)
         lpsf_pkg::WIN_COL_CMD: begin
            win_byte = lpsf_pkg::CMD_COLUMN_SET;
            win_data = 1'b0;
         end
         4'd1:    win_byte = {7'd0, cmd_ff.col_first[8]};
         4'd2:    win_byte = cmd_ff.col_first[7:0];
         4'd3:    win_byte = {7'd0, cmd_ff.col_final[8]};
         4'd4:    win_byte = cmd_ff.col_final[7:0];
         lpsf_pkg::WIN_ROW_CMD: begin
            win_byte = lpsf_pkg::CMD_ROW_SET;
            win_data = 1'b0;
         end
         4'd6:    win_byte = {7'd0, cmd_ff.row_first[8]};
         4'd7:    win_byte = cmd_ff.row_first[7:0];
         4'd8:    win_byte = {7'd0, cmd_ff.row_final[8]};
         4'd9:    win_byte = cmd_ff.row_final[7:0];
         default: begin win_byte = lpsf_pkg::CMD_MEMORY_WRITE; win_data = 1'b0; end
      endcase
   end

   // Colour channel at the current position: red, green, then blue
   assign pix_colour = (cmd_ff.kind == lpsf_pkg::KIND_RUN) ?
                       {6'd0, cmd_ff.color_value[17:0]} :
                       (rd_zero_ff ? 24'd0 : rd_data_ff);
   assign mode18     = (cmd_ff.kind == lpsf_pkg::KIND_RUN) ||
                       (cmd_ff.pixel_mode == lpsf_pkg::MODE_1BPP);

   always_comb begin
      case (bcnt_ff[1:0])
         2'd0:    pix_byte = mode18 ? {pix_colour[17:12], 2'b00} : {pix_colour[23:18], 2'b00};
         2'd1:    pix_byte = mode18 ? {pix_colour[11:6], 2'b00}  : {pix_colour[15:10], 2'b00};
         default: pix_byte = mode18 ? {pix_colour[5:0], 2'b00}   : {pix_colour[7:2], 2'b00};
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpsf_pkg::BK_IDLE: begin
            if (!q_empty) begin
               case (q_head.kind)
                  lpsf_pkg::KIND_WINDOW: state_in = lpsf_pkg::BK_WINDOW;
                  lpsf_pkg::KIND_PIXELS,
                  lpsf_pkg::KIND_RUN:    state_in = lpsf_pkg::BK_PIXEL;
                  default:               state_in = lpsf_pkg::BK_IDLE;
               endcase
            end
         end
         lpsf_pkg::BK_WINDOW: begin
            if (load_ok && bcnt_ff == lpsf_pkg::WIN_LAST) begin
               state_in = lpsf_pkg::BK_IDLE;
            end
         end
         lpsf_pkg::BK_PIXEL: begin
            if (pix_done && cnt_ff == 5'd1) begin
               state_in = lpsf_pkg::BK_IDLE;
            end
         end
         default: state_in = lpsf_pkg::BK_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      q_pop        = 1'b0;
      pal_we       = 1'b0;
      rd_en        = 1'b0;
      rd_idx       = pixel_index(q_head.pixel_byte, q_head.pixel_mode, q_head.first_pos);
      cmd_in       = cmd_ff;
      bcnt_in      = bcnt_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         lpsf_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               cmd_in  = q_head;
               bcnt_in = 4'd0;
               cnt_in  = q_head.count;
               pos_in  = q_head.first_pos;
               pal_we  = (q_head.kind == lpsf_pkg::KIND_PALETTE);
               rd_en   = (q_head.kind == lpsf_pkg::KIND_PIXELS);
            end
         end
         lpsf_pkg::BK_WINDOW: begin
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_byte_in  = win_byte;
               out_data_in  = win_data;
               out_last_in  = (bcnt_ff == lpsf_pkg::WIN_LAST);
               bcnt_in      = bcnt_ff + 4'd1;
            end
         end
         lpsf_pkg::BK_PIXEL: begin
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_byte_in  = pix_byte;
               out_data_in  = 1'b1;
               out_last_in  = pix_done && (cnt_ff == 5'd1);
               bcnt_in      = bcnt_ff + 4'd1;
            end
            // On the blue byte, fetch the next pixel so it is ready for its red byte
            if (pix_done) begin
               bcnt_in = 4'd0;
               cnt_in  = cnt_ff - 5'd1;
               pos_in  = pos_ff + 3'd1;
               rd_idx  = pixel_index(cmd_ff.pixel_byte, cmd_ff.pixel_mode, pos_ff + 3'd1);
               rd_en   = (cmd_ff.kind == lpsf_pkg::KIND_PIXELS) && (cnt_ff != 5'd1);
            end
         end
         default: ;
      endcase
   end

   assign rd_zero_in = ({1'b0, rd_idx} >= 9'(lpsf_pkg::PAL_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpsf_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      bcnt_ff     <= bcnt_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      out_byte_ff <= out_byte_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         palette_ff[q_head.table_index[lpsf_pkg::PAL_AW-1:0]] <= q_head.color_value;
      end
      if (rd_en) begin
         rd_data_ff <= palette_ff[rd_idx[lpsf_pkg::PAL_AW-1:0]];
         rd_zero_ff <= rd_zero_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_is_data   = out_data_ff;
   assign rsp_last_byte = out_last_ff;

endmodule

@@ rtl/lcd_pixel_stream_formatter_unit.sv @@
// Top level of the LCD pixel stream formatter: front end, queue and byte sequencer.
`timescale 1ns / 1ps

// Turns drawing transactions into the byte stream for an SPI TFT controller in
// 6-6-6 colour mode, one byte per result transaction, tagged command (is_data
// low) or data, with last_byte set on the final byte of each input transaction.
// The front end accepts a transaction whenever the two-entry queue has room,
// adds the column/row offsets to window corners, clips pixel counts and drops
// pixel or run transactions that yield no bytes; the back end pulls one queue
// entry at a time and emits at most one byte per cycle into an output register.
// In the back end an entry is picked up in the idle state, which also does a
// palette write; a window then emits 11 bytes and each pixel (palette lookup or
// solid run) a red, a green and a blue byte, the palette read for the next pixel
// being issued on the blue byte of the current one. The output register sets the
// pace, one byte per cycle unless rsp_stall holds it. The user must write offsets
// through the csr port (index 0 column, 1 row) only while idle; unenforced here.

module lcd_pixel_stream_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_x_first,
   input  logic [7:0]  req_y_first,
   input  logic [7:0]  req_x_final,
   input  logic [7:0]  req_y_final,
   input  logic [7:0]  req_table_index,
   input  logic [23:0] req_color_value,
   input  logic [7:0]  req_pixel_byte,
   input  logic [1:0]  req_pixel_mode,
   input  logic [2:0]  req_first_pixel,
   input  logic [4:0]  req_pixel_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_data,
   output logic        rsp_last_byte,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic               q_push;
   lpsf_pkg::cmd_type  q_push_data;
   lpsf_pkg::cmd_type  q_head;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;

   // Accept, classify and push
   lpsf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_x_first     (req_x_first),
      .req_y_first     (req_y_first),
      .req_x_final     (req_x_final),
      .req_y_final     (req_y_final),
      .req_table_index (req_table_index),
      .req_color_value (req_color_value),
      .req_pixel_byte  (req_pixel_byte),
      .req_pixel_mode  (req_pixel_mode),
      .req_first_pixel (req_first_pixel),
      .req_pixel_count (req_pixel_count),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_push_data)
   );

   // Hold classified transactions so either side may stall on its own
   lpsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Sequence bytes out, one per cycle at most
   lpsf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_last_byte (rsp_last_byte)
   );

`ifndef SYNTHESIS
   // Command bytes are only ever the three controller commands
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_data) |->
         (rsp_out_byte == lpsf_pkg::CMD_COLUMN_SET ||
          rsp_out_byte == lpsf_pkg::CMD_ROW_SET ||
          rsp_out_byte == lpsf_pkg::CMD_MEMORY_WRITE))
      else $error("unexpected command byte");

   // The memory-write command closes a window transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_data && rsp_out_byte == lpsf_pkg::CMD_MEMORY_WRITE)
         |-> rsp_last_byte)
      else $error("memory-write command not marked last");

   // Nothing is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
